/* rtl/core/sird_pkg.sv */
// ----------------------------------------------------------------------------
// sird_pkg
// Shared constants, types and state codes of the radix digit converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sird_pkg;

	localparam int MAX_SYMBOLS = 64;
	localparam int SYM_AW      = $clog2(MAX_SYMBOLS);
	localparam int RADIX_W     = 7;
	localparam int VALUE_W     = 32;
	localparam int CHAR_W      = 8;
	localparam int STACK_DEPTH = 32;
	localparam int STACK_AW    = $clog2(STACK_DEPTH);
	localparam int CNT_W       = STACK_AW + 1;
	localparam int DIV_CNT_W   = $clog2(VALUE_W);

	localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CTRL_LO  = 8'd9;
	localparam logic [CHAR_W-1:0] CTRL_HI  = 8'd13;

	localparam logic KIND_SYMBOL  = 1'b0;
	localparam logic KIND_CONVERT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_DIV,
		ST_SIGN,
		ST_POP,
		ST_SYM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic done;
		logic ok;
	} chk_stat_t;

	typedef struct packed {
		logic               done;
		logic [VALUE_W-1:0] quot;
		logic [SYM_AW-1:0]  rem;
	} div_res_t;

endpackage

`default_nettype wire

/* rtl/core/sird_ram.sv */
// ----------------------------------------------------------------------------
// sird_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

/* rtl/core/sird_check.sv */
// ----------------------------------------------------------------------------
// sird_check
// Sweeps the symbol table once per conversion and flags forbidden or
// repeated symbols with a bitmap of the byte values already seen.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_check (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire  [sird_pkg::RADIX_W-1:0]       radix,
	output logic                               rd_en,
	output logic [sird_pkg::SYM_AW-1:0]        rd_addr,
	input  wire  [sird_pkg::CHAR_W-1:0]        rd_data,
	output sird_pkg::chk_stat_t                stat
);

	logic                         busy_q;
	logic                         done_q;
	logic                         ok_q;
	logic                         pend_s1;
	logic [sird_pkg::RADIX_W-1:0] idx_q;
	logic [(1 << sird_pkg::CHAR_W)-1:0] seen_q;
	logic                         range_ok;
	logic                         bad;

	assign range_ok = (radix >= sird_pkg::RADIX_W'(2)) &&
		(radix <= sird_pkg::RADIX_W'(sird_pkg::MAX_SYMBOLS));
	assign rd_en    = busy_q && (idx_q < radix);
	assign rd_addr  = idx_q[sird_pkg::SYM_AW-1:0];

	always_comb begin
		bad = seen_q[rd_data];
		if (rd_data == sird_pkg::CH_NUL || rd_data == sird_pkg::CH_PLUS ||
				rd_data == sird_pkg::CH_MINUS) begin
			bad = 1'b1;
		end
		if (rd_data >= sird_pkg::CTRL_LO && rd_data <= sird_pkg::CTRL_HI) begin
			bad = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			ok_q    <= 1'b0;
			pend_s1 <= 1'b0;
			idx_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				ok_q    <= range_ok;
				busy_q  <= range_ok;
				done_q  <= !range_ok;
				idx_q   <= '0;
				pend_s1 <= 1'b0;
			end else if (busy_q) begin
				pend_s1 <= rd_en;
				if (rd_en) begin
					idx_q <= idx_q + sird_pkg::RADIX_W'(1);
				end
				if (pend_s1 && bad) begin
					ok_q <= 1'b0;
				end
				if (!rd_en && !pend_s1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			seen_q <= '0;
		end else if (busy_q && pend_s1) begin
			seen_q[rd_data] <= 1'b1;
		end
	end

	assign stat.done = done_q;
	assign stat.ok   = ok_q;

endmodule

`default_nettype wire

/* rtl/core/sird_div.sv */
// ----------------------------------------------------------------------------
// sird_div
// Bit-serial restoring divider: one dividend bit per cycle, giving the
// quotient and the remainder of a 32-bit magnitude by the radix.
// ----------------------------------------------------------------------------
`default_nettype none

module sird_div (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               start,
	input  wire  [sird_pkg::VALUE_W-1:0]      dividend,
	input  wire  [sird_pkg::RADIX_W-1:0]      divisor,
	output sird_pkg::div_res_t                res
);

	logic                           busy_q;
	logic                           done_q;
	logic [sird_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [sird_pkg::VALUE_W-1:0]   q_q;
	logic [sird_pkg::SYM_AW-1:0]    rem_q;
	logic [sird_pkg::RADIX_W-1:0]   dvs_q;
	logic [sird_pkg::RADIX_W-1:0]   trial;
	logic [sird_pkg::RADIX_W-1:0]   diff;
	logic                           ge;

	assign trial = {rem_q, q_q[sird_pkg::VALUE_W-1]};
	assign ge    = (trial >= dvs_q);
	assign diff  = trial - dvs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + sird_pkg::DIV_CNT_W'(1);
				if (cnt_q == sird_pkg::DIV_CNT_W'(sird_pkg::VALUE_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			q_q   <= {q_q[sird_pkg::VALUE_W-2:0], ge};
			rem_q <= ge ? diff[sird_pkg::SYM_AW-1:0] : trial[sird_pkg::SYM_AW-1:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = q_q;
	assign res.rem  = rem_q;

endmodule

`default_nettype wire

/* rtl/core/signed_integer_to_radix_digits_unit.sv */
// ----------------------------------------------------------------------------
// signed_integer_to_radix_digits_unit
// Converts a signed 32-bit value into digit characters of a loadable symbol
// table, after checking that the table is usable.
// ----------------------------------------------------------------------------
//  Channel  Signals                                      Direction
//  req      req_valid, req_stall, kind, value,           in
//           symbol_index, symbol
//  chr      chr_valid, chr_stall, character, last         out
//  cfg      cfg_we, cfg_wdata (radix)                     in
//
// A conversion with a radix in range first checks the table, then runs the
// bit-serial divider once per digit, then sends a minus sign for a negative
// value and the digit characters, most significant first; chr_stall can hold
// the output.
// One item is in work at a time; req_stall is high until it is finished.
// Reset clears the control state and radix; the symbol table holds garbage
// until written.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_integer_to_radix_digits_unit (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               req_valid,
	output logic                              req_stall,
	input  wire                               kind,
	input  wire  signed [sird_pkg::VALUE_W-1:0] value,
	input  wire  [sird_pkg::SYM_AW-1:0]       symbol_index,
	input  wire  [sird_pkg::CHAR_W-1:0]       symbol,
	output logic                              chr_valid,
	input  wire                               chr_stall,
	output logic [sird_pkg::CHAR_W-1:0]       character,
	output logic                              last,
	input  wire                               cfg_we,
	input  wire  [sird_pkg::RADIX_W-1:0]      cfg_wdata
);

	sird_pkg::state_t              state_q;
	sird_pkg::state_t              state_d;
	logic [sird_pkg::RADIX_W-1:0]  radix_q;
	logic                          neg_q;
	logic [sird_pkg::VALUE_W-1:0]  mag_q;
	logic [sird_pkg::CNT_W-1:0]    n_q;
	logic                          chr_valid_q;
	logic [sird_pkg::CHAR_W-1:0]   character_q;
	logic                          last_q;

	logic                          accept;
	logic                          slot_free;
	logic                          div_more;
	logic                          chk_start;
	logic                          div_start;
	logic                          sym_we;
	logic                          sym_re;
	logic [sird_pkg::SYM_AW-1:0]   sym_raddr;
	logic [sird_pkg::CHAR_W-1:0]   sym_rdata;
	logic                          stk_re;
	logic [sird_pkg::SYM_AW-1:0]   stk_rdata;
	logic                          out_load;
	logic [sird_pkg::CHAR_W-1:0]   out_char;
	logic                          out_last;
	logic                          chk_re;
	logic [sird_pkg::SYM_AW-1:0]   chk_addr;
	sird_pkg::chk_stat_t           chk_stat;
	sird_pkg::div_res_t            div_res;

	assign accept    = req_valid && !req_stall;
	assign slot_free = !chr_valid_q || !chr_stall;
	assign div_more  = (div_res.quot != '0) &&
		(n_q != sird_pkg::CNT_W'(sird_pkg::STACK_DEPTH - 1));

	sird_ram #(
		.WIDTH(sird_pkg::CHAR_W),
		.DEPTH(sird_pkg::MAX_SYMBOLS)
	) u_sym_ram (
		.clk  (clk),
		.we   (sym_we),
		.waddr(symbol_index),
		.wdata(symbol),
		.re   (sym_re),
		.raddr(sym_raddr),
		.rdata(sym_rdata)
	);

	sird_ram #(
		.WIDTH(sird_pkg::SYM_AW),
		.DEPTH(sird_pkg::STACK_DEPTH)
	) u_stk_ram (
		.clk  (clk),
		.we   (div_res.done),
		.waddr(n_q[sird_pkg::STACK_AW-1:0]),
		.wdata(div_res.rem),
		.re   (stk_re),
		.raddr(sird_pkg::STACK_AW'(n_q - sird_pkg::CNT_W'(1))),
		.rdata(stk_rdata)
	);

	sird_check u_check (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (chk_start),
		.radix  (radix_q),
		.rd_en  (chk_re),
		.rd_addr(chk_addr),
		.rd_data(sym_rdata),
		.stat   (chk_stat)
	);

	sird_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_res.done ? div_res.quot : mag_q),
		.divisor (radix_q),
		.res     (div_res)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			sird_pkg::ST_IDLE: begin
				if (accept && kind == sird_pkg::KIND_CONVERT) begin
					state_d = sird_pkg::ST_CHECK;
				end
			end
			sird_pkg::ST_CHECK: begin
				if (chk_stat.done) begin
					state_d = chk_stat.ok ? sird_pkg::ST_DIV : sird_pkg::ST_IDLE;
				end
			end
			sird_pkg::ST_DIV: begin
				if (div_res.done && !div_more) begin
					state_d = neg_q ? sird_pkg::ST_SIGN : sird_pkg::ST_POP;
				end
			end
			sird_pkg::ST_SIGN: begin
				if (slot_free) begin
					state_d = sird_pkg::ST_POP;
				end
			end
			sird_pkg::ST_POP: begin
				state_d = sird_pkg::ST_SYM;
			end
			sird_pkg::ST_SYM: begin
				state_d = sird_pkg::ST_OUT;
			end
			sird_pkg::ST_OUT: begin
				if (slot_free) begin
					state_d = (n_q == sird_pkg::CNT_W'(1)) ? sird_pkg::ST_IDLE
						: sird_pkg::ST_POP;
				end
			end
			default: begin
				state_d = sird_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		req_stall = 1'b1;
		sym_we    = 1'b0;
		chk_start = 1'b0;
		div_start = 1'b0;
		stk_re    = 1'b0;
		sym_re    = chk_re;
		sym_raddr = chk_addr;
		out_load  = 1'b0;
		out_char  = sym_rdata;
		out_last  = 1'b0;
		case (state_q)
			sird_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				sym_we    = accept && kind == sird_pkg::KIND_SYMBOL;
				chk_start = accept && kind == sird_pkg::KIND_CONVERT;
			end
			sird_pkg::ST_CHECK: begin
				div_start = chk_stat.done && chk_stat.ok;
			end
			sird_pkg::ST_DIV: begin
				div_start = div_res.done && div_more;
			end
			sird_pkg::ST_SIGN: begin
				out_load = slot_free;
				out_char = sird_pkg::CH_MINUS;
			end
			sird_pkg::ST_POP: begin
				stk_re = 1'b1;
			end
			sird_pkg::ST_SYM: begin
				sym_re    = 1'b1;
				sym_raddr = stk_rdata;
			end
			sird_pkg::ST_OUT: begin
				out_load = slot_free;
				out_last = (n_q == sird_pkg::CNT_W'(1));
			end
			default: begin
				req_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sird_pkg::ST_IDLE;
			radix_q     <= '0;
			chr_valid_q <= 1'b0;
			n_q         <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				radix_q <= cfg_wdata;
			end
			if (out_load) begin
				chr_valid_q <= 1'b1;
			end else if (!chr_stall) begin
				chr_valid_q <= 1'b0;
			end
			if (chk_start) begin
				n_q <= '0;
			end else if (state_q == sird_pkg::ST_DIV && div_res.done) begin
				n_q <= n_q + sird_pkg::CNT_W'(1);
			end else if (state_q == sird_pkg::ST_OUT && out_load) begin
				n_q <= n_q - sird_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chk_start) begin
			neg_q <= value[sird_pkg::VALUE_W-1];
			mag_q <= value[sird_pkg::VALUE_W-1] ? (~value + sird_pkg::VALUE_W'(1))
				: value;
		end
		if (out_load) begin
			character_q <= out_char;
			last_q      <= out_last;
		end
	end

	assign chr_valid = chr_valid_q;
	assign character = character_q;
	assign last      = last_q;

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!chr_valid_q || !chr_stall))
		else $error("Output register loaded while an item still waits.");

	a_stack_bound: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= sird_pkg::CNT_W'(sird_pkg::STACK_DEPTH))
		else $error("Digit count exceeds the stack depth.");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == sird_pkg::ST_DIV)
		else $error("Divider finished outside the division phase.");

	a_chk_state: assert property (@(posedge clk) disable iff (!arst_n)
		chk_stat.done |-> state_q == sird_pkg::ST_CHECK)
		else $error("Table check finished outside the check phase.");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sird_pkg::ST_POP |-> n_q != '0)
		else $error("Digit stack read while empty.");

endmodule

`default_nettype wire
